// ----- design/bcc_pkg.sv -----
// Shared types and register indexes for the button click classifier.
`timescale 1ns / 1ps

package bcc_pkg;

  typedef enum logic [1:0] {
    PH_UP          = 2'd0,
    PH_DOWN_BOUNCE = 2'd1,
    PH_DOWN        = 2'd2,
    PH_UP_BOUNCE   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_RELEASED   = 3'd0,
    EV_SINGLE     = 3'd1,
    EV_DOUBLE     = 3'd2,
    EV_HOLD_SHORT = 3'd3,
    EV_HOLD_LONG  = 3'd4,
    EV_SHORT_REL  = 3'd5,
    EV_LONG_REL   = 3'd6
  } event_t;

  localparam logic [1:0] CFG_SCAN_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_SHORT_HOLD    = 2'd1;
  localparam logic [1:0] CFG_LONG_HOLD     = 2'd2;
  localparam logic [1:0] CFG_CLICK_GAP     = 2'd3;

  localparam logic [7:0]  SCAN_INTERVAL_RST = 8'd10;
  localparam logic [15:0] SHORT_HOLD_RST    = 16'd2000;
  localparam logic [15:0] LONG_HOLD_RST     = 16'd5000;
  localparam logic [15:0] CLICK_GAP_RST     = 16'd200;

  typedef struct packed {
    logic [7:0]  scan_interval;
    logic [15:0] short_hold_ms;
    logic [15:0] long_hold_ms;
    logic [15:0] click_gap_ms;
  } bcc_cfg_t;

  typedef struct packed {
    phase_t phase;
    event_t key_event;
    logic   click_pending;
  } bcc_ctrl_t;

endpackage

// ----- design/bcc_core.sv -----
// Next-state logic for one tick: saturating counters and the debounce machine.
`timescale 1ns / 1ps

module bcc_core import bcc_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   pressed,
  input  bcc_cfg_t               cfg,
  input  bcc_ctrl_t              ctrl,
  input  logic [COUNT_WIDTH-1:0] scan_count,
  input  logic [COUNT_WIDTH-1:0] hold_count,
  input  logic [COUNT_WIDTH-1:0] gap_count,
  output bcc_ctrl_t              ctrl_next,
  output logic [COUNT_WIDTH-1:0] scan_next,
  output logic [COUNT_WIDTH-1:0] hold_next,
  output logic [COUNT_WIDTH-1:0] gap_next
);

  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0] scan_inc;
  logic [COUNT_WIDTH-1:0] hold_inc;
  logic [COUNT_WIDTH-1:0] gap_inc;
  logic                   eval_now;
  logic                   gap_passed;
  logic                   long_passed;
  logic                   short_passed;

  assign scan_inc = (scan_count == CNT_MAX) ? scan_count : scan_count + 1'b1;
  assign hold_inc = (hold_count == CNT_MAX) ? hold_count : hold_count + 1'b1;
  assign gap_inc  = (gap_count == CNT_MAX) ? gap_count : gap_count + 1'b1;

  // All compares use the incremented counter values, zero-extended to a common width.
  assign eval_now     = CMP_W'(scan_inc) >= CMP_W'(cfg.scan_interval);
  assign gap_passed   = CMP_W'(gap_inc) > CMP_W'(cfg.click_gap_ms);
  assign long_passed  = CMP_W'(hold_inc) > CMP_W'(cfg.long_hold_ms);
  assign short_passed = CMP_W'(hold_inc) > CMP_W'(cfg.short_hold_ms);

  always_comb begin
    ctrl_next = ctrl;
    hold_next = hold_inc;
    gap_next  = gap_inc;
    scan_next = eval_now ? '0 : scan_inc;
    if (eval_now) begin
      unique case (ctrl.phase)
        PH_UP: begin
          if (pressed) begin
            ctrl_next.phase = PH_DOWN_BOUNCE;
          end else if (ctrl.click_pending) begin
            if (gap_passed) begin
              ctrl_next.key_event     = EV_SINGLE;
              ctrl_next.click_pending = 1'b0;
            end
          end else begin
            ctrl_next.key_event = EV_RELEASED;
          end
        end
        PH_DOWN_BOUNCE: begin
          if (pressed) begin
            ctrl_next.phase = PH_DOWN;
            hold_next       = '0;
          end else begin
            ctrl_next.phase = PH_UP;
          end
        end
        PH_DOWN: begin
          if (!pressed) begin
            ctrl_next.phase = PH_UP_BOUNCE;
          end else if (long_passed) begin
            ctrl_next.key_event = EV_HOLD_LONG;
          end else if (short_passed) begin
            ctrl_next.key_event = EV_HOLD_SHORT;
          end
        end
        PH_UP_BOUNCE: begin
          if (pressed) begin
            ctrl_next.phase = PH_DOWN;
          end else begin
            ctrl_next.phase = PH_UP;
            hold_next       = '0;
            // A release after a hold ends the hold; otherwise it counts as a click.
            if (ctrl.key_event == EV_HOLD_SHORT) begin
              ctrl_next.key_event     = EV_SHORT_REL;
              ctrl_next.click_pending = 1'b0;
            end else if (ctrl.key_event == EV_HOLD_LONG) begin
              ctrl_next.key_event     = EV_LONG_REL;
              ctrl_next.click_pending = 1'b0;
            end else if (ctrl.click_pending) begin
              ctrl_next.key_event     = EV_DOUBLE;
              ctrl_next.click_pending = 1'b0;
            end else begin
              ctrl_next.click_pending = 1'b1;
              gap_next                = '0;
            end
          end
        end
        default: begin
          ctrl_next = ctrl;
        end
      endcase
    end
  end

endmodule

// ----- design/button_click_classifier.sv -----
// Top level of the button click classifier: registers, handshake and result buffer.
`timescale 1ns / 1ps

// Usage: each transaction on the s_ channel is one millisecond tick that carries
// the button level in s_tdata[0] (1 means pressed). For every accepted tick the
// block returns one transaction on the m_ channel with the current event code
// and debounce phase. Results come out in tick order, one per tick.
// Results are registered. Throughput is one tick per cycle while the skid register
// is empty; the counters and debounce machine are updated combinationally from the
// state registers. Registers are written through cfg_we, cfg_addr and cfg_wdata
// (0 scan interval, 1 short hold, 2 long hold, 3 click gap); the user must write
// them only while no tick is in flight, as the block does not enforce it.
// Reset (rst, synchronous) clears the counters, sets the phase to up, the event
// to released, and loads the register defaults 10, 2000, 5000 and 200.
// When the receiver stalls, the result stays on m_tdata and one more tick is
// still taken into a skid register; after that s_tready drops until the output
// drains. No transaction is lost or repeated.
module button_click_classifier import bcc_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [0] pressed, [7:1] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [2:0] key_event, [4:3] debounce_phase, [7:5] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  bcc_cfg_t               cfg;
  bcc_ctrl_t              ctrl;
  bcc_ctrl_t              ctrl_next;
  logic [COUNT_WIDTH-1:0] scan_count;
  logic [COUNT_WIDTH-1:0] hold_count;
  logic [COUNT_WIDTH-1:0] gap_count;
  logic [COUNT_WIDTH-1:0] scan_next;
  logic [COUNT_WIDTH-1:0] hold_next;
  logic [COUNT_WIDTH-1:0] gap_next;
  logic [7:0]             result;
  logic [7:0]             skid_data;
  logic                   skid_valid;
  logic                   in_acc;
  logic                   out_take;

  assign s_tready = !skid_valid;
  assign in_acc   = s_tvalid && s_tready;
  assign out_take = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_interval <= SCAN_INTERVAL_RST;
      cfg.short_hold_ms <= SHORT_HOLD_RST;
      cfg.long_hold_ms  <= LONG_HOLD_RST;
      cfg.click_gap_ms  <= CLICK_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SCAN_INTERVAL: cfg.scan_interval <= cfg_wdata[7:0];
        CFG_SHORT_HOLD:    cfg.short_hold_ms <= cfg_wdata;
        CFG_LONG_HOLD:     cfg.long_hold_ms  <= cfg_wdata;
        CFG_CLICK_GAP:     cfg.click_gap_ms  <= cfg_wdata;
        default:           cfg.scan_interval <= cfg.scan_interval;
      endcase
    end
  end

  bcc_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .pressed    (s_tdata[0]),
    .cfg        (cfg),
    .ctrl       (ctrl),
    .scan_count (scan_count),
    .hold_count (hold_count),
    .gap_count  (gap_count),
    .ctrl_next  (ctrl_next),
    .scan_next  (scan_next),
    .hold_next  (hold_next),
    .gap_next   (gap_next)
  );

  assign result = {3'b000, ctrl_next.phase, ctrl_next.key_event};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.phase         <= PH_UP;
      ctrl.key_event     <= EV_RELEASED;
      ctrl.click_pending <= 1'b0;
      scan_count         <= '0;
      hold_count         <= '0;
      gap_count          <= '0;
    end else if (in_acc) begin
      ctrl       <= ctrl_next;
      scan_count <= scan_next;
      hold_count <= hold_next;
      gap_count  <= gap_next;
    end
  end

  // Output register plus one skid entry, so a tick is taken while a result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !m_tvalid) begin
      m_tdata <= skid_valid ? skid_data : result;
    end
    if (in_acc && m_tvalid && !out_take) begin
      skid_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry held while output register is empty");

  // Without an evaluation on the tick the phase simply stays in down bouncing.
  a_bounce_exit: assert property (@(posedge clk) disable iff (rst)
    (in_acc && ctrl.phase == PH_DOWN_BOUNCE) |=> (ctrl.phase != PH_UP_BOUNCE))
    else $error("down bouncing phase left to an illegal phase");

  a_ctrl_holds: assert property (@(posedge clk) disable iff (rst)
    !in_acc |=> $stable(ctrl))
    else $error("machine state changed without an accepted tick");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (out_take && skid_valid) |=> (m_tvalid && m_tdata == $past(skid_data)))
    else $error("skid entry not moved to the output register");
`endif

endmodule

// ----- tb/button_click_classifier_checker.sv -----
// Result checker for the button click classifier: predicts each tick's report and compares it.
`timescale 1ns / 1ps

module button_click_classifier_checker import bcc_pkg::*; #(
  parameter int COUNT_WIDTH = 16,
  parameter int MAX_REPORTS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,    // [0] pressed, [7:1] zero
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,    // [2:0] key_event, [4:3] debounce_phase, [7:5] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    event_t key_event;
    phase_t debounce_phase;
  } click_report_t;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  bcc_cfg_t               cfg;
  logic [COUNT_WIDTH-1:0] scan_ms;
  logic [COUNT_WIDTH-1:0] hold_ms;
  logic [COUNT_WIDTH-1:0] gap_ms;
  phase_t                 phase_q;
  event_t                 event_q;
  logic                   click_waiting;
  click_report_t          expected_reports[$];
  click_report_t          want;
  int                     fail_count;
  int                     results_seen;

  function automatic logic [COUNT_WIDTH-1:0] sat_up(input logic [COUNT_WIDTH-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  // Advances the predicted classifier by one millisecond tick.
  task automatic classify_tick(input logic pressed, output click_report_t rep);
    scan_ms = sat_up(scan_ms);
    hold_ms = sat_up(hold_ms);
    gap_ms  = sat_up(gap_ms);
    if (scan_ms >= cfg.scan_interval) begin
      scan_ms = '0;
      case (phase_q)
        PH_UP: begin
          if (pressed) begin
            phase_q = PH_DOWN_BOUNCE;
          end else if (click_waiting) begin
            if (gap_ms > cfg.click_gap_ms) begin
              event_q       = EV_SINGLE;
              click_waiting = 1'b0;
            end
          end else begin
            event_q = EV_RELEASED;
          end
        end
        PH_DOWN_BOUNCE: begin
          if (pressed) begin
            phase_q = PH_DOWN;
            hold_ms = '0;
          end else begin
            phase_q = PH_UP;
          end
        end
        PH_DOWN: begin
          if (!pressed) begin
            phase_q = PH_UP_BOUNCE;
          end else if (hold_ms > cfg.long_hold_ms) begin
            event_q = EV_HOLD_LONG;
          end else if (hold_ms > cfg.short_hold_ms) begin
            event_q = EV_HOLD_SHORT;
          end
        end
        default: begin
          if (pressed) begin
            phase_q = PH_DOWN;
          end else begin
            phase_q = PH_UP;
            // A release ends a hold, completes a double click, or opens the click window.
            if (event_q == EV_HOLD_SHORT) begin
              event_q       = EV_SHORT_REL;
              click_waiting = 1'b0;
            end else if (event_q == EV_HOLD_LONG) begin
              event_q       = EV_LONG_REL;
              click_waiting = 1'b0;
            end else if (click_waiting) begin
              event_q       = EV_DOUBLE;
              click_waiting = 1'b0;
            end else begin
              click_waiting = 1'b1;
              gap_ms        = '0;
            end
            hold_ms = '0;
          end
        end
      endcase
    end
    rep.key_event      = event_q;
    rep.debounce_phase = phase_q;
  endtask

  task automatic flag_error(input string what, input int exp_val, input int act_val);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t: result %0d: %s expected %0d, got %0d",
               $realtime, results_seen, what, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg.scan_interval = SCAN_INTERVAL_RST;
      cfg.short_hold_ms = SHORT_HOLD_RST;
      cfg.long_hold_ms  = LONG_HOLD_RST;
      cfg.click_gap_ms  = CLICK_GAP_RST;
      scan_ms       = '0;
      hold_ms       = '0;
      gap_ms        = '0;
      phase_q       = PH_UP;
      event_q       = EV_RELEASED;
      click_waiting = 1'b0;
      expected_reports.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      // The result side is handled first so that a tick accepted at this edge
      // is never matched against a result leaving at the same edge.
      if (m_tvalid && m_tready) begin
        if (expected_reports.size() == 0) begin
          flag_error("result with no tick outstanding, key_event", -1, m_tdata[2:0]);
        end else begin
          want = expected_reports.pop_front();
          if (m_tdata[2:0] != want.key_event) begin
            flag_error("key_event", want.key_event, m_tdata[2:0]);
          end
          if (m_tdata[4:3] != want.debounce_phase) begin
            flag_error("debounce_phase", want.debounce_phase, m_tdata[4:3]);
          end
          if (m_tdata[7:5] != 3'b000) begin
            flag_error("padding", 0, m_tdata[7:5]);
          end
        end
        results_seen++;
      end
      if (s_tvalid && s_tready) begin
        classify_tick(s_tdata[0], want);
        expected_reports.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_SCAN_INTERVAL: cfg.scan_interval = cfg_wdata[7:0];
          CFG_SHORT_HOLD:    cfg.short_hold_ms = cfg_wdata;
          CFG_LONG_HOLD:     cfg.long_hold_ms  = cfg_wdata;
          CFG_CLICK_GAP:     cfg.click_gap_ms  = cfg_wdata;
          default: ;
        endcase
      end
    end
    mismatches <= fail_count;
    pending    <= expected_reports.size();
  end

endmodule

// ----- tb/button_click_classifier_tb.sv -----
// Testbench top for the button click classifier: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module button_click_classifier_tb;
  import bcc_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int LONG_STALL   = 300;
  localparam int LATENCY      = 1;
  localparam int PHASE_TICKS  = 45;

  localparam logic [1:0] REG_ORDER [4] = '{CFG_SCAN_INTERVAL, CFG_SHORT_HOLD,
                                          CFG_LONG_HOLD, CFG_CLICK_GAP};
  localparam int SEND_IDLE [4] = '{0, 78, 0, 30};
  localparam int RECV_IDLE [4] = '{0, 0, 78, 30};

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic [7:0]  s_tdata   = 8'h00;
  logic        m_tready  = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_addr  = CFG_SCAN_INTERVAL;
  logic [15:0] cfg_wdata = 16'h0000;
  logic        s_tready;
  logic        m_tvalid;
  logic [7:0]  m_tdata;

  int mismatches;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit stall_request  = 1'b0;
  int ticks_sent     = 0;
  int settings_used  = 0;
  int quiet_cycles   = 0;

  button_click_classifier u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  button_click_classifier_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_request) begin
        m_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        stall_request = 1'b0;
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_tick(input logic pressed);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, pressed};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic send_run(input logic pressed, input int n);
    repeat (n) send_tick(pressed);
  endtask

  // Holds the sender back until every outstanding report has come out.
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // The upper byte of the scan interval word is junk that the block must drop.
  task automatic write_regs(input logic [7:0] scan, input logic [15:0] short_hold,
                            input logic [15:0] long_hold, input logic [15:0] gap);
    logic [15:0] vals [4];
    vals = '{{8'($urandom), scan}, short_hold, long_hold, gap};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= REG_ORDER[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly clean clicks and holds sized to the scan interval, with some bounce noise.
  task automatic random_gestures(input int n_ticks, input int unit);
    int target;
    target = ticks_sent + n_ticks;
    while (ticks_sent < target) begin
      case ($urandom_range(4))
        0, 1: begin
          send_run(1'b1, unit * $urandom_range(2, 5));
          send_run(1'b0, unit * $urandom_range(2, 4));
        end
        2: begin
          send_run(1'b1, $urandom_range(unit * 2, 70));
          send_run(1'b0, unit * $urandom_range(2, 6));
        end
        3: begin
          repeat ($urandom_range(2, 5)) send_run($urandom_range(1), $urandom_range(1, unit));
        end
        default: begin
          send_run(1'b0, $urandom_range(1, 40));
        end
      endcase
    end
  endtask

  initial begin
    int scan;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: one evaluation per ten ticks.
    send_run(1'b1, 10);
    drain;

    // Zero scan interval evaluates every tick; tiny thresholds reach every event.
    write_regs(8'd0, 16'd2, 16'd4, 16'd1);
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    send_run(1'b1, 2);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 2);
    send_run(1'b1, 2);
    send_run(1'b0, 2);
    send_run(1'b1, 7);
    send_run(1'b0, 2);
    send_run(1'b1, 5);
    send_run(1'b0, 2);
    send_run(1'b1, 2);
    send_run(1'b0, 4);
    drain;

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = SEND_IDLE[p];
      recv_stall_pct = RECV_IDLE[p];
      for (int c = 0; c < 2; c++) begin
        scan = $urandom_range(0, 3);
        if (p == 0 && c == 0) begin
          write_regs(8'd1, 16'd0, 16'd0, 16'd0);
        end else if (p == 1 && c == 0) begin
          write_regs(8'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        end else begin
          write_regs(scan[7:0], 16'($urandom_range(0, 25)), 16'($urandom_range(0, 50)),
                     16'($urandom_range(0, 20)));
        end
        if (p == 0 && c == 1) begin
          stall_request = 1'b1;
        end
        random_gestures(PHASE_TICKS, (scan < 1) ? 1 : scan);
        drain;
      end
    end

    $display("Run covered %0d ticks under %0d register settings, four idle and stall mixes",
             ticks_sent, settings_used);
    $display("and thresholds from zero to full scale, with every event code reached.");
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
